// ----- hw/rtl/cbm_pkg.sv -----
`timescale 1ns / 1ps

package cbm_pkg;

    localparam logic [2:0] REGION_RAM_EN   = 3'b000;
    localparam logic [2:0] REGION_ROM_BANK = 3'b001;
    localparam logic [2:0] REGION_BANK_SEL = 3'b010;
    localparam logic [2:0] REGION_LATCH    = 3'b011;
    localparam logic [2:0] REGION_WINDOW   = 3'b101;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    localparam logic [7:0] SEL_RTC_SEC  = 8'h08;
    localparam logic [7:0] SEL_RTC_MIN  = 8'h09;
    localparam logic [7:0] SEL_RTC_HOUR = 8'h0A;
    localparam logic [7:0] SEL_RTC_DAY  = 8'h0B;
    localparam logic [7:0] SEL_RTC_CTRL = 8'h0C;
    localparam logic [7:0] SEL_RAM_LAST = 8'h03;

    localparam logic [7:0] SEC_MAX    = 8'd59;
    localparam logic [7:0] HOUR_MAX   = 8'd23;
    localparam logic [7:0] CTRL_MASK  = 8'hC1;
    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [6:0] ROM_BANK_MIN = 7'd1;

    localparam int RTC_REGS = 5;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_from_sram;
        logic        sram_write;
        logic [12:0] sram_offset;
        logic [7:0]  sram_wdata;
        logic [6:0]  rom_bank_now;
        logic [1:0]  ram_bank_now;
    } rsp_item_t;

endpackage

// ----- hw/rtl/cbm_if.sv -----
`timescale 1ns / 1ps

interface cbm_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, action, address, write_data, input ready);
    modport sink (input valid, action, address, write_data, output ready);
endinterface

interface cbm_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        read_from_sram;
    logic        sram_write;
    logic [12:0] sram_offset;
    logic [7:0]  sram_wdata;
    logic [6:0]  rom_bank_now;
    logic [1:0]  ram_bank_now;

    modport source (output valid, read_data, read_from_sram, sram_write, sram_offset,
                    sram_wdata, rom_bank_now, ram_bank_now, input ready);
    modport sink (input valid, read_data, read_from_sram, sram_write, sram_offset,
                  sram_wdata, rom_bank_now, ram_bank_now, output ready);
endinterface

// ----- hw/rtl/cbm_in_stage.sv -----
`timescale 1ns / 1ps

module cbm_in_stage
    import cbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cbm_req_if.sink    req,
    input  logic       advance,
    output logic       item_valid,
    output req_item_t  item
);

    logic      valid_reg;
    logic      valid_next;
    req_item_t item_reg;
    logic      take;

    assign req.ready  = !valid_reg || advance;
    assign take       = req.valid && req.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{action: req.action, address: req.address,
                          write_data: req.write_data};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hw/rtl/cbm_core.sv -----
`timescale 1ns / 1ps

module cbm_core
    import cbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       advance,
    input  req_item_t  item,
    output rsp_item_t  result
);

    logic       sram_present_reg;
    logic       ram_en_reg, ram_en_next;
    logic [6:0] rom_bank_reg, rom_bank_next;
    logic [7:0] bank_sel_reg, bank_sel_next;
    logic [1:0] ram_bank_reg, ram_bank_next;
    logic       latch_prev_reg, latch_prev_next;
    logic       latched_reg, latched_next;
    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;
    logic [8:0] day_reg, day_next;
    logic [7:0] ctrl_reg, ctrl_next;
    logic [7:0] copy_reg [RTC_REGS];
    logic [7:0] copy_next [RTC_REGS];

    logic [7:0] live [RTC_REGS];
    logic [7:0] live_val;
    logic [7:0] copy_val;
    logic       rtc_sel;
    logic [7:0] val;
    logic [7:0] ctrl_masked;
    logic [6:0] rom_req;

    assign live[0] = {2'b00, sec_reg};
    assign live[1] = {2'b00, min_reg};
    assign live[2] = {3'b000, hour_reg};
    assign live[3] = day_reg[7:0];
    assign live[4] = ctrl_reg;

    assign rtc_sel     = bank_sel_reg inside {[SEL_RTC_SEC:SEL_RTC_CTRL]};
    assign val         = item.write_data;
    assign ctrl_masked = val & CTRL_MASK;
    assign rom_req     = val[6:0];

    always_comb
    begin
        case (bank_sel_reg)
            SEL_RTC_SEC:  begin live_val = live[0]; copy_val = copy_reg[0]; end
            SEL_RTC_MIN:  begin live_val = live[1]; copy_val = copy_reg[1]; end
            SEL_RTC_HOUR: begin live_val = live[2]; copy_val = copy_reg[2]; end
            SEL_RTC_DAY:  begin live_val = live[3]; copy_val = copy_reg[3]; end
            default:      begin live_val = live[4]; copy_val = copy_reg[4]; end
        endcase
    end

    always_comb
    begin
        ram_en_next     = ram_en_reg;
        rom_bank_next   = rom_bank_reg;
        bank_sel_next   = bank_sel_reg;
        ram_bank_next   = ram_bank_reg;
        latch_prev_next = latch_prev_reg;
        latched_next    = latched_reg;
        sec_next        = sec_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        day_next        = day_reg;
        ctrl_next       = ctrl_reg;
        copy_next       = copy_reg;
        result          = '0;

        if (!item.action)
        begin
            if (!ram_en_reg)
            begin
                result.read_data = BYTE_IDLE;
            end
            else if (rtc_sel)
            begin
                result.read_data = latched_reg ? copy_val : live_val;
            end
            else if (sram_present_reg)
            begin
                result.read_from_sram = 1'b1;
                result.sram_offset    = item.address[12:0];
            end
            else
            begin
                result.read_data = BYTE_IDLE;
            end
        end
        else
        begin
            case (item.address[15:13])
                REGION_RAM_EN:
                begin
                    ram_en_next = (val[3:0] == RAM_EN_KEY);
                end
                REGION_ROM_BANK:
                begin
                    rom_bank_next = (rom_req == 7'd0) ? ROM_BANK_MIN : rom_req;
                end
                REGION_BANK_SEL:
                begin
                    if (val <= SEL_RAM_LAST)
                    begin
                        bank_sel_next = val;
                        ram_bank_next = val[1:0];
                    end
                    else if (val inside {[SEL_RTC_SEC:SEL_RTC_CTRL]})
                    begin
                        bank_sel_next = val;
                    end
                end
                REGION_LATCH:
                begin
                    if (!latch_prev_reg && val[0])
                    begin
                        copy_next    = live;
                        latched_next = 1'b1;
                    end
                    latch_prev_next = val[0];
                end
                REGION_WINDOW:
                begin
                    if (ram_en_reg)
                    begin
                        case (bank_sel_reg)
                            SEL_RTC_SEC:  sec_next  = (val > SEC_MAX) ? SEC_MAX[5:0] : val[5:0];
                            SEL_RTC_MIN:  min_next  = (val > SEC_MAX) ? SEC_MAX[5:0] : val[5:0];
                            SEL_RTC_HOUR: hour_next = (val > HOUR_MAX) ? HOUR_MAX[4:0] : val[4:0];
                            SEL_RTC_DAY:  day_next  = {day_reg[8], val};
                            SEL_RTC_CTRL:
                            begin
                                day_next  = {ctrl_masked[0], day_reg[7:0]};
                                ctrl_next = ctrl_masked;
                            end
                            default:
                            begin
                                if (sram_present_reg)
                                begin
                                    result.sram_write  = 1'b1;
                                    result.sram_offset = item.address[12:0];
                                    result.sram_wdata  = val;
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end

        result.rom_bank_now = rom_bank_next;
        result.ram_bank_now = ram_bank_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sram_present_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            sram_present_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_en_reg     <= 1'b0;
            rom_bank_reg   <= ROM_BANK_MIN;
            bank_sel_reg   <= '0;
            ram_bank_reg   <= '0;
            latch_prev_reg <= 1'b0;
            latched_reg    <= 1'b0;
            sec_reg        <= '0;
            min_reg        <= '0;
            hour_reg       <= '0;
            day_reg        <= '0;
            ctrl_reg       <= '0;
            for (int i = 0; i < RTC_REGS; i++)
            begin
                copy_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            ram_en_reg     <= ram_en_next;
            rom_bank_reg   <= rom_bank_next;
            bank_sel_reg   <= bank_sel_next;
            ram_bank_reg   <= ram_bank_next;
            latch_prev_reg <= latch_prev_next;
            latched_reg    <= latched_next;
            sec_reg        <= sec_next;
            min_reg        <= min_next;
            hour_reg       <= hour_next;
            day_reg        <= day_next;
            ctrl_reg       <= ctrl_next;
            copy_reg       <= copy_next;
        end
    end

endmodule

// ----- hw/rtl/cbm_out_stage.sv -----
`timescale 1ns / 1ps

module cbm_out_stage
    import cbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  rsp_item_t  result,
    output logic       busy,
    cbm_rsp_if.source  rsp
);

    logic      valid_reg;
    logic      valid_next;
    rsp_item_t result_reg;

    assign valid_next = advance ? 1'b1 : (rsp.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    // stage can load when empty or when its transfer completes this cycle
    assign busy               = valid_reg && !rsp.ready;
    assign rsp.valid          = valid_reg;
    assign rsp.read_data      = result_reg.read_data;
    assign rsp.read_from_sram = result_reg.read_from_sram;
    assign rsp.sram_write     = result_reg.sram_write;
    assign rsp.sram_offset    = result_reg.sram_offset;
    assign rsp.sram_wdata     = result_reg.sram_wdata;
    assign rsp.rom_bank_now   = result_reg.rom_bank_now;
    assign rsp.ram_bank_now   = result_reg.ram_bank_now;

endmodule

// ----- hw/rtl/cartridge_bank_mapper_rtc_unit.sv -----
`timescale 1ns / 1ps

// channel  | direction | contents
// ---------+-----------+-------------------------------------------------------
// req      | in        | action, address, write_data
// rsp      | out       | read_data, read_from_sram, sram_write, sram_offset,
//          |           | sram_wdata, rom_bank_now, ram_bank_now
// cfg      | in        | cfg_we, cfg_wdata (sram_present)
//
// one access per clock sustained while rsp is ready; a result passes through the request
// register, then the decode and mapper state update, then the result register
// reset (rst_n low) clears all mapper and clock state, rom bank to 1, sram_present to 1
// a stalled rsp holds its result while req still takes one more access into its register

module cartridge_bank_mapper_rtc_unit
    import cbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    cbm_req_if.sink    req,
    cbm_rsp_if.source  rsp
);

    logic      item_valid;
    req_item_t item;
    rsp_item_t result;
    logic      out_busy;
    logic      advance;

    assign advance = item_valid && !out_busy;

    cbm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cbm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    cbm_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .result  (result),
        .busy    (out_busy),
        .rsp     (rsp)
    );

    a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.rom_bank_now != 7'd0)
        else $error("rom bank zero on result");

    a_sram_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.read_from_sram && rsp.sram_write))
        else $error("sram read and write in one result");

    a_sram_read_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.read_from_sram |-> rsp.read_data == 8'd0)
        else $error("register data on sram read");

    a_advance_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp.valid)
        else $error("result lost after advance");

endmodule
